@@ hdl/assert_macros.svh @@
// Assertion helpers for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset.
`define AST_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Same, on the block's own clock and reset names.
`define AST_ASSERT_CLK(name, prop) `AST_ASSERT(name, clk_i, rst_ni, prop)

`endif

@@ hdl/ast_pkg.sv @@
package ast_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned RES_PER_ITEM    = 3;
  localparam int unsigned FIFO_DEPTH      = 4;
  localparam int unsigned NUM_KW          = 9;

  typedef enum logic [3:0] {
    M_IDLE,
    M_SECT,
    M_REG,
    M_LABEL,
    M_WORD,
    M_NUM,
    M_EQW,
    M_DASHW,
    M_COMMENT
  } mode_e;

  // token kinds
  localparam logic [4:0] K_CODE  = 5'd0;
  localparam logic [4:0] K_DATA  = 5'd1;
  localparam logic [4:0] K_REG   = 5'd2;
  localparam logic [4:0] K_LABEL = 5'd3;
  localparam logic [4:0] K_EQ    = 5'd4;
  localparam logic [4:0] K_QMARK = 5'd5;
  localparam logic [4:0] K_VAR   = 5'd6;
  localparam logic [4:0] K_KW0   = 5'd7;
  localparam logic [4:0] K_NAME  = 5'd16;
  localparam logic [4:0] K_INT   = 5'd17;
  localparam logic [4:0] K_NONE  = 5'd18;

  // fault codes
  localparam logic [1:0] F_NONE    = 2'd0;
  localparam logic [1:0] F_SECTION = 2'd1;
  localparam logic [1:0] F_EQUALS  = 2'd2;
  localparam logic [1:0] F_DASH    = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;

  // prefix words hold the first byte in the low byte
  localparam logic [39:0] TXT_CODE = {"e", "d", "o", "c", "#"};
  localparam logic [39:0] TXT_DATA = {"a", "t", "a", "d", "#"};

  localparam logic [39:0] KW_TEXT [NUM_KW] = '{
    {8'd0, "t", "i", "x", "e"},
    {16'd0, "d", "d", "a"},
    {16'd0, "b", "u", "s"},
    {16'd0, "v", "o", "m"},
    {8'd0, "m", "u", "n", "e"},
    {24'd0, "f", "i"},
    {24'd0, "n", "i"},
    {8'd0, "e", "s", "l", "e"},
    {16'd0, "d", "n", "e"}
  };
  localparam logic [15:0] KW_LEN [NUM_KW] = '{
    16'd4, 16'd3, 16'd3, 16'd3, 16'd4, 16'd2, 16'd2, 16'd4, 16'd3
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [1:0]  fault;
    logic [15:0] start_offset;
    logic [15:0] text_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        final_res;
  } res_item_t;

  typedef struct packed {
    logic [1:0]                    cnt;
    res_item_t [RES_PER_ITEM-1:0]  item;
  } push_t;

  typedef struct packed {
    logic      vld;
    logic      halt;
    res_item_t res;
  } close_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // bytes past the open length are zero, so a full-word compare plus length works
  function automatic logic text_is(input logic [39:0] prefix, input logic [15:0] len,
                                   input logic [39:0] txt, input logic [15:0] tlen);
    return (prefix == txt) && (len == tlen);
  endfunction

  function automatic close_t close_tok(input mode_e m, input logic [39:0] prefix,
                                       input logic [15:0] len, input logic [15:0] st,
                                       input logic [15:0] st1, input logic [15:0] line,
                                       input logic [15:0] col);
    close_t     r;
    logic [4:0] k;
    r                   = '0;
    k                   = K_NAME;
    r.res.kind          = K_NONE;
    r.res.fault         = F_NONE;
    r.res.start_offset  = st;
    r.res.text_length   = len;
    r.res.line_number   = line;
    r.res.column_number = col;
    case (m)
      M_SECT: begin
        r.vld = 1'b1;
        if (text_is(prefix, len, TXT_CODE, 16'd5)) begin
          r.res.kind = K_CODE;
        end else if (text_is(prefix, len, TXT_DATA, 16'd5)) begin
          r.res.kind = K_DATA;
        end else begin
          r.res.fault = F_SECTION;
          r.halt      = 1'b1;
        end
      end
      M_REG, M_LABEL: begin
        r.vld               = 1'b1;
        r.res.kind          = (m == M_REG) ? K_REG : K_LABEL;
        r.res.start_offset  = st1;
        r.res.text_length   = len - 16'd1;
      end
      M_WORD: begin
        r.vld = 1'b1;
        if (prefix[7:0] == ".") begin
          k = K_VAR;
        end else begin
          for (int i = 0; i < NUM_KW; i++) begin
            if (text_is(prefix, len, KW_TEXT[i], KW_LEN[i])) k = K_KW0 + 5'(i);
          end
        end
        r.res.kind = k;
      end
      M_NUM: begin
        r.vld      = 1'b1;
        r.res.kind = K_INT;
      end
      M_EQW, M_DASHW: begin
        r.vld             = 1'b1;
        r.halt            = 1'b1;
        r.res.fault       = (m == M_EQW) ? F_EQUALS : F_DASH;
        r.res.text_length = 16'd1;
      end
      default: begin
        r.vld = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

@@ hdl/ast_res_fifo.sv @@
module ast_res_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ast_pkg::push_t    push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ast_pkg::res_item_t out_data_o
);
  import ast_pkg::*;

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  res_item_t           mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];
  // room for a whole byte's worth of results, counting this cycle's pop
  assign room_o      = (cnt_q - CntW'(pop)) <= CntW'(FIFO_DEPTH - RES_PER_ITEM);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RES_PER_ITEM; i++) begin
      if (2'(i) < push_i.cnt) mem_q[wr_ptr_q + PtrW'(i)] <= push_i.item[i];
    end
  end

endmodule

@@ hdl/ast_lexer.sv @@
module ast_lexer #(
  parameter int unsigned OffsetBits = ast_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  ast_pkg::in_item_t item_i,
  output ast_pkg::push_t    push_o
);
  import ast_pkg::*;

  mode_e                 mode_q, mode_d;
  logic [39:0]           prefix_q, prefix_d;
  logic [15:0]           len_q, len_d;
  logic [OffsetBits-1:0] start_q, start_d;
  logic [OffsetBits-1:0] offset_q, offset_d;
  logic [15:0]           line_q, line_d, col_q, col_d;
  logic [15:0]           oline_q, oline_d, ocol_q, ocol_d;
  logic                  halted_q, halted_d;

  logic [7:0]            c;
  logic                  last;
  logic                  used, halt, body_ok;
  logic [39:0]           app_prefix;
  logic [15:0]           app_len;
  logic [OffsetBits+15:0] st_ext_q, st1_ext_q, st_ext_d, st1_ext_d, off_ext;
  close_t                cl0, cl2;
  logic [2:0]            r_v;
  res_item_t             r [3];
  logic [1:0]            idx;

  assign c    = item_i.ch;
  assign last = item_i.last;

  // zero-extend, then keep the low 16 bits whatever the counter width
  assign st_ext_q  = {16'd0, start_q};
  assign st1_ext_q = {16'd0, start_q + OffsetBits'(1)};
  assign off_ext   = {16'd0, offset_q};

  assign app_prefix = (len_q < 16'd5) ? (prefix_q | (40'(c) << {len_q[2:0], 3'b000}))
                                      : prefix_q;
  assign app_len    = sat_inc16(len_q);

  assign cl0 = close_tok(mode_q, prefix_q, len_q, st_ext_q[15:0], st1_ext_q[15:0],
                         oline_q, ocol_q);

  always_comb begin
    mode_d    = mode_q;
    prefix_d  = prefix_q;
    len_d     = len_q;
    start_d   = start_q;
    offset_d  = offset_q;
    line_d    = line_q;
    col_d     = col_q;
    oline_d   = oline_q;
    ocol_d    = ocol_q;
    halted_d  = halted_q;
    used      = 1'b0;
    halt      = 1'b0;
    body_ok   = 1'b0;
    r_v       = '0;
    r[0]      = '0;
    r[1]      = '0;
    r[2]      = '0;
    st_ext_d  = '0;
    st1_ext_d = '0;
    cl2       = '0;

    if (go_i && !halted_q) begin
      // does this byte continue the open token?
      case (mode_q)
        M_SECT, M_REG, M_LABEL: body_ok = (c != CH_SPACE) && (c != CH_NL);
        M_WORD:                 body_ok = is_alpha(c) || (c == "_") || (c == ".");
        M_NUM:                  body_ok = is_digit(c) || (c == ".");
        default:                body_ok = 1'b0;
      endcase

      case (mode_q)
        M_SECT, M_REG, M_LABEL, M_WORD, M_NUM: begin
          if (body_ok) begin
            prefix_d = app_prefix;
            len_d    = app_len;
            used     = 1'b1;
          end else begin
            r_v[0] = cl0.vld;
            r[0]   = cl0.res;
            halt   = cl0.halt;
            mode_d = M_IDLE;
          end
        end
        M_EQW: begin
          if (c == "=") begin
            r_v[0]              = 1'b1;
            r[0].kind           = K_EQ;
            r[0].fault          = F_NONE;
            r[0].start_offset   = st_ext_q[15:0];
            r[0].text_length    = 16'd2;
            r[0].line_number    = oline_q;
            r[0].column_number  = ocol_q;
            mode_d              = M_IDLE;
            used                = 1'b1;
          end else begin
            r_v[0] = cl0.vld;
            r[0]   = cl0.res;
            halt   = cl0.halt;
            mode_d = M_IDLE;
          end
        end
        M_DASHW: begin
          if (c == "-") begin
            mode_d = M_COMMENT;
            used   = 1'b1;
          end else begin
            r_v[0] = cl0.vld;
            r[0]   = cl0.res;
            halt   = cl0.halt;
            mode_d = M_IDLE;
          end
        end
        M_COMMENT: begin
          if (c != CH_NL) used = 1'b1;
          else mode_d = M_IDLE;
        end
        default: begin
          mode_d = M_IDLE;
        end
      endcase

      if (!halt) begin
        if (!used) begin
          if ((c == "#") || (c == "$") || (c == ":") || (c == "=") || (c == "-") ||
              is_alpha(c) || (c == ".") || is_digit(c)) begin
            start_d  = offset_q;
            len_d    = 16'd1;
            prefix_d = 40'(c);
            oline_d  = line_q;
            ocol_d   = col_q;
            if (c == "#") mode_d = M_SECT;
            else if (c == "$") mode_d = M_REG;
            else if (c == ":") mode_d = M_LABEL;
            else if (c == "=") mode_d = M_EQW;
            else if (c == "-") mode_d = M_DASHW;
            else if (is_digit(c)) mode_d = M_NUM;
            else mode_d = M_WORD;
          end else if (c == "?") begin
            r_v[1]             = 1'b1;
            r[1].kind          = K_QMARK;
            r[1].fault         = F_NONE;
            r[1].start_offset  = off_ext[15:0];
            r[1].text_length   = 16'd1;
            r[1].line_number   = line_q;
            r[1].column_number = col_q;
          end
        end

        if (last) begin
          // flush whatever is open after this byte
          st_ext_d  = {16'd0, start_d};
          st1_ext_d = {16'd0, start_d + OffsetBits'(1)};
          cl2 = close_tok(mode_d, prefix_d, len_d, st_ext_d[15:0], st1_ext_d[15:0],
                          oline_d, ocol_d);
          if (mode_d != M_COMMENT) begin
            r_v[2] = cl2.vld;
            r[2]   = cl2.res;
            halt   = cl2.halt;
          end
          mode_d = M_IDLE;
          if (r_v == 3'b000) begin
            // end marker
            r_v[2]             = 1'b1;
            r[2].kind          = K_NONE;
            r[2].fault         = F_NONE;
            r[2].start_offset  = off_ext[15:0];
            r[2].text_length   = 16'd0;
            r[2].line_number   = line_q;
            r[2].column_number = col_q;
          end
        end

        offset_d = offset_q + OffsetBits'(1);
        if (c == CH_NL) begin
          line_d = sat_inc16(line_q);
          col_d  = 16'd1;
        end else begin
          col_d  = sat_inc16(col_q);
        end
      end

      halted_d = halt;

      if (last) begin
        if (r_v[2]) r[2].final_res = 1'b1;
        else if (r_v[1]) r[1].final_res = 1'b1;
        else if (r_v[0]) r[0].final_res = 1'b1;
      end

      if (last && !halt) begin
        mode_d   = M_IDLE;
        prefix_d = '0;
        len_d    = '0;
        start_d  = '0;
        offset_d = '0;
        line_d   = 16'd1;
        col_d    = 16'd1;
        oline_d  = 16'd1;
        ocol_d   = 16'd1;
      end
    end
  end

  // pack valid results in order
  always_comb begin
    push_o = '0;
    idx    = '0;
    for (int i = 0; i < RES_PER_ITEM; i++) begin
      if (r_v[i]) begin
        push_o.item[idx] = r[i];
        idx              = idx + 2'd1;
      end
    end
    push_o.cnt = idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      prefix_q <= '0;
      len_q    <= '0;
      start_q  <= '0;
      offset_q <= '0;
      line_q   <= 16'd1;
      col_q    <= 16'd1;
      oline_q  <= 16'd1;
      ocol_q   <= 16'd1;
      halted_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      prefix_q <= prefix_d;
      len_q    <= len_d;
      start_q  <= start_d;
      offset_q <= offset_d;
      line_q   <= line_d;
      col_q    <= col_d;
      oline_q  <= oline_d;
      ocol_q   <= ocol_d;
      halted_q <= halted_d;
    end
  end

endmodule

@@ hdl/assembly_source_tokenizer_top.sv @@
// Streaming tokenizer for assembly source: takes one byte per request (with a
// last flag on the final byte) and returns token requests carrying kind,
// fault, offset, length, line and column. A byte is taken every cycle while
// the input register is empty or its byte moves on; the byte is held in the
// input register, where the lexer state is updated and its results (zero to
// three) are written to a 4-entry result queue, from which they are offered
// on the output. The held byte moves on only while the queue has room for
// three results, counting a result leaving in the same cycle. Results leave
// one per cycle while the receiver is ready, so the sustained rate is one
// byte per cycle as long as bytes yield on average at most one result; each
// result beyond one per byte takes an extra output slot, which the queue's
// slack absorbs at first and which then shows as a stall on the input
// through the free-space check. A byte with last set yields at least one
// result unless the block is already halted, and the last result it yields
// has final_res set. A section, lone '=' or lone '-' fault halts the block:
// later bytes are still taken but give no results until reset.
module assembly_source_tokenizer_top #(
  parameter int unsigned OffsetBits = ast_pkg::OFFSET_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ast_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ast_pkg::res_item_t out_data_o
);
  import ast_pkg::*;

  in_item_t in_q;
  logic     in_vld_q;
  logic     room;
  logic     proc;
  push_t    push;

  // the held byte is processed once the queue can take all of its results
  assign proc       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  ast_lexer #(
    .OffsetBits(OffsetBits)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (proc),
    .item_i (in_q),
    .push_o (push)
  );

  ast_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hdl/ast_checker.sv @@
`include "assert_macros.svh"

module ast_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input ast_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ast_pkg::res_item_t out_data_o
);
  import ast_pkg::*;

  // a stalled result stays offered
  `AST_ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o)

  // and keeps its payload
  `AST_ASSERT_CLK(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o))

  // an empty queue refills only from a byte taken in, by way of the input register
  `AST_ASSERT_CLK(a_rise_src, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))

  // a result of no kind and no fault is the end marker
  `AST_ASSERT_CLK(a_end_marker, out_valid_o && out_data_o.kind == K_NONE && out_data_o.fault == F_NONE |-> out_data_o.final_res && out_data_o.text_length == 16'd0)

endmodule

bind assembly_source_tokenizer_top ast_checker u_ast_checker (.*);

@@ tb/tokenizer_checker.sv @@
module tokenizer_checker
  import ast_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  res_item_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  string keyword_text [9] = '{"exit", "add", "sub", "mov", "enum", "if", "in", "else", "end"};

  // lexer state as the block should hold it
  mode_e       lex_mode;
  logic [39:0] head_bytes;
  logic [15:0] tok_len, tok_start, tok_line, tok_col;
  logic [15:0] offset, line_no, col_no;
  bit          stopped;

  res_item_t   batch [3];
  int          nb;
  res_item_t   expected_tokens [$];
  int unsigned fails = 0;

  function automatic logic [15:0] inc_sat(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic bit letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic bit digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit text_equals(input string s);
    if (tok_len != 16'(s.len())) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (head_bytes[8*i +: 8] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic restart();
    lex_mode   = M_IDLE;
    head_bytes = '0;
    tok_len    = '0;
    tok_start  = '0;
    offset     = '0;
    line_no    = 16'd1;
    col_no     = 16'd1;
    tok_line   = 16'd1;
    tok_col    = 16'd1;
  endtask

  task automatic add_result(input logic [4:0] k, input logic [1:0] f, input logic [15:0] s,
                            input logic [15:0] n, input logic [15:0] ln, input logic [15:0] cl);
    if (nb < 3) begin
      batch[nb] = '{kind: k, fault: f, start_offset: s, text_length: n, line_number: ln,
                    column_number: cl, final_res: 1'b0};
      nb++;
    end
  endtask

  task automatic open_token(input mode_e m, input logic [7:0] c);
    lex_mode   = m;
    tok_start  = offset;
    tok_len    = 16'd1;
    head_bytes = {32'd0, c};
    tok_line   = line_no;
    tok_col    = col_no;
  endtask

  task automatic grow(input logic [7:0] c);
    int unsigned pos;
    pos = tok_len;
    if (tok_len < 16'd5) head_bytes[8*pos +: 8] = c;
    tok_len = inc_sat(tok_len);
  endtask

  task automatic close_token();
    logic [4:0] k;
    k = K_NAME;
    case (lex_mode)
      M_SECT: begin
        if (text_equals("#code")) begin
          add_result(K_CODE, F_NONE, tok_start, tok_len, tok_line, tok_col);
        end else if (text_equals("#data")) begin
          add_result(K_DATA, F_NONE, tok_start, tok_len, tok_line, tok_col);
        end else begin
          add_result(K_NONE, F_SECTION, tok_start, tok_len, tok_line, tok_col);
          stopped = 1'b1;
        end
      end
      M_REG, M_LABEL: begin
        // sigil is stripped from the reported text
        add_result((lex_mode == M_REG) ? K_REG : K_LABEL, F_NONE, tok_start + 16'd1,
                   tok_len - 16'd1, tok_line, tok_col);
      end
      M_WORD: begin
        if (head_bytes[7:0] == ".") begin
          k = K_VAR;
        end else begin
          for (int i = 0; i < 9; i++) begin
            if (text_equals(keyword_text[i])) k = K_KW0 + 5'(i);
          end
        end
        add_result(k, F_NONE, tok_start, tok_len, tok_line, tok_col);
      end
      M_NUM: begin
        add_result(K_INT, F_NONE, tok_start, tok_len, tok_line, tok_col);
      end
      M_EQW, M_DASHW: begin
        add_result(K_NONE, (lex_mode == M_EQW) ? F_EQUALS : F_DASH, tok_start, 16'd1,
                   tok_line, tok_col);
        stopped = 1'b1;
      end
      default: begin
      end
    endcase
    lex_mode = M_IDLE;
  endtask

  // one source byte in, zero to three expected tokens queued
  task automatic tokenize_byte(input logic [7:0] c, input logic last);
    bit          taken;
    logic [15:0] here_off, here_line, here_col;
    taken = 1'b0;
    nb    = 0;
    if (stopped) return;
    case (lex_mode)
      M_SECT, M_REG, M_LABEL: begin
        if ((c != CH_SPACE) && (c != CH_NL)) begin
          grow(c);
          taken = 1'b1;
        end else begin
          close_token();
        end
      end
      M_WORD: begin
        if (letter(c) || (c == "_") || (c == ".")) begin
          grow(c);
          taken = 1'b1;
        end else begin
          close_token();
        end
      end
      M_NUM: begin
        if (digit(c) || (c == ".")) begin
          grow(c);
          taken = 1'b1;
        end else begin
          close_token();
        end
      end
      M_EQW: begin
        if (c == "=") begin
          add_result(K_EQ, F_NONE, tok_start, 16'd2, tok_line, tok_col);
          lex_mode = M_IDLE;
          taken    = 1'b1;
        end else begin
          close_token();
        end
      end
      M_DASHW: begin
        if (c == "-") begin
          lex_mode = M_COMMENT;
          taken    = 1'b1;
        end else begin
          close_token();
        end
      end
      M_COMMENT: begin
        if (c != CH_NL) taken = 1'b1;
        else lex_mode = M_IDLE;
      end
      default: begin
        lex_mode = M_IDLE;
      end
    endcase

    if (!stopped) begin
      // byte not absorbed: it may start a token; anything else is dropped
      if (!taken) begin
        if (c == "#") open_token(M_SECT, c);
        else if (c == "$") open_token(M_REG, c);
        else if (c == ":") open_token(M_LABEL, c);
        else if (c == "=") open_token(M_EQW, c);
        else if (c == "-") open_token(M_DASHW, c);
        else if (c == "?") add_result(K_QMARK, F_NONE, offset, 16'd1, line_no, col_no);
        else if (letter(c) || (c == ".")) open_token(M_WORD, c);
        else if (digit(c)) open_token(M_NUM, c);
      end
      if (last) begin
        here_off  = offset;
        here_line = line_no;
        here_col  = col_no;
        if (lex_mode != M_COMMENT) close_token();
        lex_mode = M_IDLE;
        if (nb == 0) add_result(K_NONE, F_NONE, here_off, 16'd0, here_line, here_col);
      end
      offset = offset + 16'd1;
      if (c == CH_NL) begin
        line_no = inc_sat(line_no);
        col_no  = 16'd1;
      end else begin
        col_no = inc_sat(col_no);
      end
    end

    if (last && (nb > 0)) batch[nb-1].final_res = 1'b1;
    if (last && !stopped) restart();
    for (int i = 0; i < nb; i++) expected_tokens = {expected_tokens, batch[i]};
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_item_t want;
    if (!rst_ni) begin
      restart();
      stopped = 1'b0;
      expected_tokens.delete();
    end else begin
      if (in_valid_i && in_ready_i) tokenize_byte(in_data_i.ch, in_data_i.last);
      if (out_valid_i && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          $error("token with none expected: kind %0d fault %0d offset %0d",
                 out_data_i.kind, out_data_i.fault, out_data_i.start_offset);
          fails++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("kind", want.kind, out_data_i.kind);
          check_field("fault", want.fault, out_data_i.fault);
          check_field("start_offset", want.start_offset, out_data_i.start_offset);
          check_field("text_length", want.text_length, out_data_i.text_length);
          check_field("line_number", want.line_number, out_data_i.line_number);
          check_field("column_number", want.column_number, out_data_i.column_number);
          check_field("final_res", want.final_res, out_data_i.final_res);
        end
      end
    end
    pending_o    <= expected_tokens.size();
    fail_count_o <= fails;
  end

endmodule

@@ tb/tb.sv @@
module tb;
  import ast_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run guard: generous against the slowest legal run
  localparam int unsigned CycleLimit  = 1_000_000;
  // long receiver hold-off, enough to back the block up into its input
  localparam int unsigned HoldCycles  = 400;
  // post-drain window, run once no expected token is pending
  localparam int unsigned DrainCycles = 20;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  res_item_t out_data_o;

  int unsigned fail_count, pending;

  // idle rates in percent, changed between phases
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 80;

  logic        hold_go    = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;

  // source text under construction, one byte per request
  logic [7:0] src [$];

  string keyword_text [9] = '{"exit", "add", "sub", "mov", "enum", "if", "in", "else", "end"};

  always #1 clk_i = ~clk_i;

  assembly_source_tokenizer_top dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  tokenizer_checker token_check (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i   (in_ready_o),
    .in_data_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Receiver side. A one-shot hold-off request from the stimulus loads a
  // long count here; while it runs, ready stays low so the result queue
  // fills and the block stops taking bytes.
  always @(posedge clk_i) begin
    if (hold_go && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [7:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  // continuation byte of a word: letter, underscore or dot
  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 9))
      0:       return "_";
      1:       return ".";
      default: return rand_letter();
    endcase
  endfunction

  function automatic logic [7:0] blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_NL;
  endfunction

  // a byte that starts no token and is simply dropped by the lexer
  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
               ((c >= "0") && (c <= "9")) || (c == ".") || (c == "#") || (c == "$") ||
               (c == ":") || (c == "=") || (c == "-") || (c == "?"));
    return c;
  endfunction

  // append one byte to the source
  task automatic add_byte(input logic [7:0] c);
    src = {src, c};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // One well-formed token (or filler). Section, register and label tokens
  // always end in a blank so they never swallow what follows; a section
  // that swallowed text would be unknown and halt the block for good.
  task automatic add_token();
    logic [7:0]  c;
    string       kw;
    int unsigned n;
    case ($urandom_range(0, 11))
      0: begin
        push_text($urandom_range(0, 1) ? "#code" : "#data");
        add_byte(blank());
      end
      1, 2: begin
        add_byte($urandom_range(0, 1) ? "$" : ":");
        n = $urandom_range(0, 6);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255)); while ((c == CH_SPACE) || (c == CH_NL));
          add_byte(c);
        end
        add_byte(blank());
      end
      3: push_text("==");
      4: add_byte("?");
      5: begin
        add_byte(".");
        repeat ($urandom_range(0, 5)) add_byte(word_char());
      end
      6: push_text(keyword_text[$urandom_range(0, 8)]);
      7: begin
        // names, many of them one byte off a keyword
        kw = keyword_text[$urandom_range(0, 8)];
        case ($urandom_range(0, 2))
          0: push_text(kw.substr(0, kw.len() - 2));
          1: begin
            push_text(kw);
            add_byte(word_char());
          end
          default: begin
            add_byte(rand_letter());
            repeat ($urandom_range(0, 7)) add_byte(word_char());
          end
        endcase
      end
      8: begin
        add_byte(8'("0" + $urandom_range(0, 9)));
        repeat ($urandom_range(0, 5)) begin
          add_byte(($urandom_range(0, 4) == 0) ? 8'(".") : 8'("0" + $urandom_range(0, 9)));
        end
      end
      9: begin
        push_text("--");
        repeat ($urandom_range(0, 8)) begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_NL);
          add_byte(c);
        end
        add_byte(CH_NL);
      end
      10: repeat ($urandom_range(1, 3)) add_byte(noise_byte());
      default: add_byte(blank());
    endcase
    if ($urandom_range(0, 1)) add_byte($urandom_range(0, 3) ? blank() : noise_byte());
  endtask

  task automatic build_source();
    int unsigned target;
    target = $urandom_range(3, 30);
    while (src.size() < target) add_token();
  endtask

  // One byte request. A gap lowers valid first and raises it at a later edge,
  // so valid never drops and rises within one time step.
  task automatic send_byte(input logic [7:0] c, input logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{ch: c, last: last};
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  // send the buffered source, last flag on its final byte
  task automatic send_source();
    for (int i = 0; i < src.size(); i++) send_byte(src[i], i == src.size() - 1);
    src.delete();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: sender idles 16%, receiver 80%.
    // Directed: both sections, register with an all-ones body, empty label,
    // "==", "?", a zero byte dropped, variable, keyword, integer with dot,
    // a name flushed by the last flag.
    push_text("#code\n#data $");
    add_byte(8'hff);
    push_text(" : ==?");
    add_byte(8'h00);
    push_text(".v in 9.1 Zz_");
    send_source();
    // source ending inside a comment: only the end marker comes back
    push_text("--");
    add_byte(8'h80);
    send_source();
    // "?" as the whole source carries the final flag itself
    add_byte("?");
    send_source();
    // a lone blank gives just the end marker
    add_byte(CH_SPACE);
    send_source();

    while (bytes_sent < 180) begin
      build_source();
      send_source();
    end

    // Phase 2: the other way round.
    send_idle_pct = 80;
    recv_idle_pct = 16;
    while (bytes_sent < 340) begin
      build_source();
      send_source();
    end

    // Phase 3: no idling. Receiver holds off for a long stretch while
    // bytes keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go <= 1'b1;
    while (bytes_sent < 520) begin
      build_source();
      send_source();
    end

    // Last source ends in a fault; the block then halts for the rest of the
    // run, so only one fault kind fits per run and the seed picks it.
    build_source();
    case ($urandom_range(0, 3))
      0: begin
        // unknown section
        if ($urandom_range(0, 1)) begin
          push_text("#code");
          add_byte(rand_letter());
        end else begin
          add_byte("#");
          repeat ($urandom_range(0, 3)) add_byte(rand_letter());
        end
        add_byte(blank());
        push_text("ab ?\n");
      end
      1: begin
        // lone equals
        add_byte("=");
        add_byte(noise_byte());
        push_text("ab ?\n");
      end
      2: begin
        // lone dash
        add_byte("-");
        add_byte(noise_byte());
        push_text("ab ?\n");
      end
      default: begin
        // lone '=' or '-' as the very last byte
        add_byte($urandom_range(0, 1) ? "=" : "-");
      end
    endcase
    send_source();
    // halted: these requests are taken but give nothing
    push_text("x 1 ?");
    send_source();

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if ((fail_count == 0) && (pending == 0)) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/ast_pkg.sv
hdl/ast_res_fifo.sv
hdl/ast_lexer.sv
hdl/assembly_source_tokenizer_top.sv
hdl/ast_checker.sv
tb/tokenizer_checker.sv
tb/tb.sv
